### sv/hsa_pkg.sv
// Shared types, field widths and codes for the handle slot allocator.
package hsa_pkg;

  localparam int MODE_W   = 3;
  localparam int IDX_IN_W = 16;
  localparam int VAL_W    = 32;
  localparam int TIME_W   = 32;
  localparam int RIDX_W   = 10;
  localparam int KIND_W   = 2;
  localparam int UCNT_W   = 11;

  localparam int SLOTS_DEFAULT = 1024;
  localparam logic [TIME_W-1:0] HOLD_RESET = 32'd180;

  localparam logic [MODE_W-1:0] MODE_ALLOC = 3'd0;
  localparam logic [MODE_W-1:0] MODE_GET   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_STOP  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_FIRST = 3'd3;
  localparam logic [MODE_W-1:0] MODE_NEXT  = 3'd4;
  localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd5;

  localparam logic [KIND_W-1:0] NOTE_NONE     = 2'd0;
  localparam logic [KIND_W-1:0] NOTE_CLOSED   = 2'd1;
  localparam logic [KIND_W-1:0] NOTE_RELEASED = 2'd2;

  typedef enum logic [1:0] {
    ST_FREE   = 2'd0,
    ST_USED   = 2'd1,
    ST_CLOSED = 2'd2
  } slot_status_t;

  typedef struct packed {
    slot_status_t      status;
    logic [TIME_W-1:0] ctime;
    logic [VAL_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    logic              ok;
    logic [RIDX_W-1:0] ridx;
    logic [VAL_W-1:0]  rval;
    logic [KIND_W-1:0] nkind;
    logic [VAL_W-1:0]  nval;
  } result_t;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_SCAN,
    S_OUT
  } state_t;

endpackage

### sv/hsa_if.sv
// Command and response channel interfaces of the handle slot allocator.
interface hsa_cmd_if import hsa_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [MODE_W-1:0]   mode;
  logic [IDX_IN_W-1:0] slot_index;
  logic [VAL_W-1:0]    entry_value;
  logic [TIME_W-1:0]   now_time;

  modport source (output valid, mode, slot_index, entry_value, now_time, input ready);
  modport sink (input valid, mode, slot_index, entry_value, now_time, output ready);
endinterface

interface hsa_rsp_if import hsa_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              ok;
  logic [RIDX_W-1:0] result_index;
  logic [VAL_W-1:0]  result_value;
  logic [KIND_W-1:0] notify_kind;
  logic [VAL_W-1:0]  notify_value;
  logic [UCNT_W-1:0] used_count;

  modport source (output valid, ok, result_index, result_value, notify_kind, notify_value,
                  used_count, input ready);
  modport sink (input valid, ok, result_index, result_value, notify_kind, notify_value,
                used_count, output ready);
endinterface

### sv/handle_slot_allocator_delayed_reuse_unit.sv
// Top level of the handle slot allocator with delayed reuse.

// All slot state (status, close time, value) lives in one synchronous memory with a
// registered read, and each command beat is worked on alone. Get and stop read one
// slot. Allocate, first and next scan the memory one slot per cycle through its single
// read port, and stop early when a match comes. Commands that fail at acceptance (an
// unknown mode, an index out of range, or first or next on an empty table) skip the
// scan and go straight to the response. After reset, and for every clear command, a
// sweep writes every slot free, one slot per cycle; no command beat is accepted during
// the sweep, while hold_time writes are taken at any time.
module handle_slot_allocator_delayed_reuse_unit import hsa_pkg::*; #(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  hsa_cmd_if.sink           cmd,
  hsa_rsp_if.source         rsp,
  input  logic              cfg_we,
  input  logic [TIME_W-1:0] cfg_wdata
);

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  state_t state, state_next;

  entry_t slot_mem [SLOTS];
  entry_t rd_data;

  logic [TIME_W-1:0] hold_time;
  logic [MODE_W-1:0] op_mode;
  logic [VAL_W-1:0]  op_val;
  logic [TIME_W-1:0] op_now;
  logic [IW-1:0]     addr;
  logic [IW-1:0]     rd_idx;
  logic [IW:0]       issued;
  logic [IW:0]       len;
  logic              rvalid;
  logic              sweep_reply;
  logic [CW-1:0]     used_total;
  result_t           res;
  result_t           res_next;
  result_t           res_start;
  logic              out_valid;

  logic          accept;
  logic          in_range;
  logic          start_fail;
  logic          hit;
  logic          finish;
  logic          issue;
  logic          out_load;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  entry_t        wr_data;

  function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] a);
    return (a == IW'(SLOTS - 1)) ? '0 : a + 1'b1;
  endfunction

  assign accept   = cmd.valid && cmd.ready;
  assign in_range = {1'b0, cmd.slot_index} < (IDX_IN_W + 1)'(SLOTS);
  assign out_load = (state == S_OUT) && (!out_valid || rsp.ready);

  always_comb begin
    start_fail = 1'b0;
    unique case (cmd.mode)
      MODE_ALLOC, MODE_CLEAR: start_fail = 1'b0;
      MODE_GET, MODE_STOP: start_fail = !in_range;
      MODE_FIRST: start_fail = (used_total == '0);
      MODE_NEXT: start_fail = !in_range || (used_total == '0);
      default: start_fail = 1'b1;
    endcase
    res_start    = '0;
    res_start.ok = (cmd.mode == MODE_CLEAR);
  end

  // Match test on the slot returned by the memory and the write-back it causes, or the sweep write of a free slot.
  always_comb begin
    hit      = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = rd_idx;
    wr_data  = rd_data;
    res_next = '0;
    if (state == S_SWEEP) begin
      wr_en   = 1'b1;
      wr_addr = addr;
      wr_data = '0;
    end else if (state == S_SCAN && rvalid) begin
      unique case (op_mode)
        MODE_ALLOC: begin
          if (rd_data.status == ST_FREE) begin
            hit = 1'b1;
          end else if (hold_time != '0 && rd_data.status == ST_CLOSED &&
                       (op_now - rd_data.ctime) > hold_time) begin
            hit = 1'b1;
            if (rd_data.value != '0) begin
              res_next.nkind = NOTE_RELEASED;
              res_next.nval  = rd_data.value;
            end
          end
          if (hit) begin
            wr_en          = 1'b1;
            wr_data.status = ST_USED;
            wr_data.value  = op_val;
          end
        end
        MODE_GET: begin
          hit = (rd_data.status == ST_USED);
          if (hit) begin
            res_next.rval = rd_data.value;
          end
        end
        MODE_STOP: begin
          hit = (rd_data.status == ST_USED);
          if (hit) begin
            wr_en = 1'b1;
            if (hold_time != '0) begin
              wr_data.status = ST_CLOSED;
              wr_data.ctime  = op_now;
              if (rd_data.value != '0) begin
                res_next.nkind = NOTE_CLOSED;
                res_next.nval  = rd_data.value;
              end
            end else begin
              wr_data.status = ST_FREE;
              if (rd_data.value != '0) begin
                res_next.nkind = NOTE_RELEASED;
                res_next.nval  = rd_data.value;
              end
            end
          end
        end
        MODE_FIRST, MODE_NEXT: hit = (rd_data.status == ST_USED);
        default: hit = 1'b0;
      endcase
      if (hit) begin
        res_next.ok   = 1'b1;
        res_next.ridx = RIDX_W'(rd_idx);
      end
    end
  end

  assign finish = (state == S_SCAN) && rvalid && (hit || issued == len);

  always_comb begin
    state_next = state;
    unique case (state)
      S_SWEEP: begin
        if (addr == IW'(SLOTS - 1)) begin
          state_next = sweep_reply ? S_OUT : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (cmd.mode == MODE_CLEAR) begin
            state_next = S_SWEEP;
          end else if (start_fail) begin
            state_next = S_OUT;
          end else begin
            state_next = S_SCAN;
          end
        end
      end
      S_SCAN: begin
        if (finish) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
    endcase
  end

  always_comb begin
    cmd.ready = (state == S_IDLE);
    issue     = (state == S_SCAN) && (issued != len) && !(rvalid && hit);
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_data <= slot_mem[addr];
    end
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      addr        <= '0;
      sweep_reply <= 1'b0;
      rvalid      <= 1'b0;
      used_total  <= '0;
      out_valid   <= 1'b0;
      hold_time   <= HOLD_RESET;
    end else begin
      state  <= state_next;
      rvalid <= issue;
      if (cfg_we) begin
        hold_time <= cfg_wdata;
      end
      if (state == S_SWEEP) begin
        addr <= addr + 1'b1;
      end
      if (accept) begin
        sweep_reply <= 1'b1;
        unique case (cmd.mode)
          MODE_GET, MODE_STOP: addr <= IW'(cmd.slot_index);
          MODE_NEXT: addr <= wrap_inc(IW'(cmd.slot_index));
          default: addr <= '0;
        endcase
        if (cmd.mode == MODE_CLEAR) begin
          used_total <= '0;
        end
      end else if (issue) begin
        addr <= wrap_inc(addr);
      end
      if (hit && op_mode == MODE_ALLOC) begin
        used_total <= used_total + 1'b1;
      end else if (hit && op_mode == MODE_STOP) begin
        used_total <= used_total - 1'b1;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_mode <= cmd.mode;
      op_val  <= cmd.entry_value;
      op_now  <= cmd.now_time;
      issued  <= '0;
      res     <= res_start;
      if (cmd.mode == MODE_GET || cmd.mode == MODE_STOP) begin
        len <= (IW + 1)'(1);
      end else begin
        len <= (IW + 1)'(SLOTS);
      end
    end else if (issue) begin
      issued <= issued + 1'b1;
    end
    if (issue) begin
      rd_idx <= addr;
    end
    if (finish) begin
      res <= res_next;
    end
    if (out_load) begin
      rsp.ok           <= res.ok;
      rsp.result_index <= res.ridx;
      rsp.result_value <= res.rval;
      rsp.notify_kind  <= res.nkind;
      rsp.notify_value <= res.nval;
      rsp.used_count   <= UCNT_W'(used_total);
    end
  end

  assign rsp.valid = out_valid;

  a_used_bound: assert property (@(posedge clk) disable iff (rst)
    used_total <= CW'(SLOTS))
    else $error("used slot count exceeds the table size");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    state == S_SCAN |-> issued <= len)
    else $error("scan issued more reads than its length");

  a_no_rw_overlap: assert property (@(posedge clk) disable iff (rst)
    !(issue && wr_en))
    else $error("slot memory read and written in the same cycle");

  a_rsp_from_out: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp.valid) |-> $past(state) == S_OUT)
    else $error("response beat raised outside the output state");

endmodule

### sim/hsa_tb_pkg.sv
`timescale 1ns / 100ps
// Scoreboard class that predicts and checks the response beats of the handle slot allocator.
package hsa_tb_pkg;
  import hsa_pkg::*;

  typedef struct packed {
    logic              ok;
    logic [RIDX_W-1:0] ridx;
    logic [VAL_W-1:0]  rval;
    logic [KIND_W-1:0] nkind;
    logic [VAL_W-1:0]  nval;
    logic [UCNT_W-1:0] used;
  } slot_rsp_t;

  class slot_table_scoreboard;
    slot_status_t      status [SLOTS_DEFAULT];
    logic [TIME_W-1:0] closed_at [SLOTS_DEFAULT];
    logic [VAL_W-1:0]  stored [SLOTS_DEFAULT];
    int unsigned       in_use;
    logic [TIME_W-1:0] hold_time;
    slot_rsp_t         expected_rsps [$];
    int unsigned       mismatches;
    int unsigned       beats_checked;
    int unsigned       mode_hits [8];
    int unsigned       reuses;
    int unsigned       full_misses;

    function new();
      wipe_table();
      hold_time = HOLD_RESET;
      mismatches = 0;
      beats_checked = 0;
      reuses = 0;
      full_misses = 0;
      foreach (mode_hits[m]) mode_hits[m] = 0;
    endfunction

    function void wipe_table();
      foreach (status[s]) begin
        status[s] = ST_FREE;
        closed_at[s] = '0;
        stored[s] = '0;
      end
      in_use = 0;
    endfunction

    // Returns some slot in use, or a random in-range slot when the table is empty.
    function logic [IDX_IN_W-1:0] pick_used();
      int start;
      int i;
      int s;
      start = $urandom_range(SLOTS_DEFAULT - 1);
      for (i = 0; i < SLOTS_DEFAULT; i++) begin
        s = (start + i) % SLOTS_DEFAULT;
        if (status[s] == ST_USED) return s[IDX_IN_W-1:0];
      end
      return start[IDX_IN_W-1:0];
    endfunction

    function void note_command(input logic [MODE_W-1:0] mode, input logic [IDX_IN_W-1:0] idx,
                               input logic [VAL_W-1:0] val, input logic [TIME_W-1:0] now);
      slot_rsp_t         r;
      int                slot;
      int                i;
      int                k;
      logic [TIME_W-1:0] age;
      r = '0;
      slot = -1;
      mode_hits[mode]++;
      case (mode)
        MODE_ALLOC: begin
          for (i = 0; i < SLOTS_DEFAULT && slot < 0; i++) begin
            age = now - closed_at[i];
            if (status[i] == ST_FREE) begin
              slot = i;
            end else if (hold_time != 0 && status[i] == ST_CLOSED && age > hold_time) begin
              if (stored[i] != 0) begin
                r.nkind = NOTE_RELEASED;
                r.nval = stored[i];
              end
              slot = i;
              reuses++;
            end
          end
          if (slot >= 0) begin
            stored[slot] = val;
            closed_at[slot] = '0;
            status[slot] = ST_USED;
            in_use++;
            r.ok = 1'b1;
            r.ridx = slot[RIDX_W-1:0];
          end else begin
            full_misses++;
          end
        end
        MODE_GET: begin
          if (idx < SLOTS_DEFAULT && status[idx] == ST_USED) begin
            r.ok = 1'b1;
            r.ridx = idx[RIDX_W-1:0];
            r.rval = stored[idx];
          end
        end
        MODE_STOP: begin
          if (idx < SLOTS_DEFAULT && status[idx] == ST_USED) begin
            if (stored[idx] != 0) begin
              r.nkind = (hold_time != 0) ? NOTE_CLOSED : NOTE_RELEASED;
              r.nval = stored[idx];
            end
            if (hold_time != 0) begin
              closed_at[idx] = now;
              status[idx] = ST_CLOSED;
            end else begin
              stored[idx] = '0;
              closed_at[idx] = '0;
              status[idx] = ST_FREE;
            end
            in_use--;
            r.ok = 1'b1;
            r.ridx = idx[RIDX_W-1:0];
          end
        end
        MODE_FIRST: begin
          for (i = 0; i < SLOTS_DEFAULT && slot < 0; i++) begin
            if (status[i] == ST_USED) slot = i;
          end
          if (slot >= 0) begin
            r.ok = 1'b1;
            r.ridx = slot[RIDX_W-1:0];
          end
        end
        MODE_NEXT: begin
          if (idx < SLOTS_DEFAULT && in_use > 0) begin
            for (k = 1; k <= SLOTS_DEFAULT && slot < 0; k++) begin
              i = (int'(idx) + k) % SLOTS_DEFAULT;
              if (status[i] == ST_USED) slot = i;
            end
            if (slot >= 0) begin
              r.ok = 1'b1;
              r.ridx = slot[RIDX_W-1:0];
            end
          end
        end
        MODE_CLEAR: begin
          wipe_table();
          r.ok = 1'b1;
        end
        default: begin
        end
      endcase
      r.used = in_use[UCNT_W-1:0];
      expected_rsps.push_back(r);
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, actual %0h", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_response(input slot_rsp_t got);
      slot_rsp_t want;
      if (expected_rsps.size() == 0) begin
        $error("Response beat with no command outstanding: ok=%0d index=%0d", got.ok, got.ridx);
        mismatches++;
        return;
      end
      want = expected_rsps.pop_front();
      beats_checked++;
      compare_field("ok", 32'(want.ok), 32'(got.ok));
      compare_field("result_index", 32'(want.ridx), 32'(got.ridx));
      compare_field("result_value", want.rval, got.rval);
      compare_field("notify_kind", 32'(want.nkind), 32'(got.nkind));
      compare_field("notify_value", want.nval, got.nval);
      compare_field("used_count", 32'(want.used), 32'(got.used));
    endfunction
  endclass

endpackage

### sim/handle_slot_allocator_delayed_reuse_unit_tb.sv
`timescale 1ns / 100ps
// Testbench of the handle slot allocator: directed cases, a partial fill and random traffic.
module handle_slot_allocator_delayed_reuse_unit_tb;
  import hsa_pkg::*;
  import hsa_tb_pkg::*;

  localparam int SLOTS = SLOTS_DEFAULT;
  localparam longint unsigned CYCLE_LIMIT = 64'd8_000_000;
  localparam int SQUEEZE_CYCLES = 600;
  localparam int DRAIN_CYCLES = SLOTS + 64;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 75;
  localparam int FILL_ITEMS = 64;
  localparam logic [MODE_W-1:0] MODE_BAD_LO = 3'd6;
  localparam logic [MODE_W-1:0] MODE_BAD_HI = 3'd7;

  logic              clk;
  logic              rst;
  logic              cfg_we;
  logic [TIME_W-1:0] cfg_wdata;

  hsa_cmd_if cmd_ch ();
  hsa_rsp_if rsp_ch ();

  handle_slot_allocator_delayed_reuse_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  slot_table_scoreboard table_sb;
  longint unsigned      cycle_count = 0;
  int                   burst_left;
  logic [TIME_W-1:0]    clock_s;
  logic [TIME_W-1:0]    phase_holds [PHASES];
  logic                 squeeze_req;
  logic                 squeeze_taken = 1'b0;
  int                   squeeze_left = 0;
  int                   stall_style = 0;
  int                   style_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin : rsp_side
    slot_rsp_t seen;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      seen.ok = rsp_ch.ok;
      seen.ridx = rsp_ch.result_index;
      seen.rval = rsp_ch.result_value;
      seen.nkind = rsp_ch.notify_kind;
      seen.nval = rsp_ch.notify_value;
      seen.used = rsp_ch.used_count;
      table_sb.check_response(seen);
    end
    if (squeeze_req && !squeeze_taken) begin
      squeeze_taken <= 1'b1;
      squeeze_left <= SQUEEZE_CYCLES;
      rsp_ch.ready <= 1'b0;
    end else if (squeeze_left > 0) begin
      squeeze_left <= squeeze_left - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      if (style_left == 0) begin
        stall_style <= $urandom_range(3);
        style_left <= $urandom_range(300, 40);
      end else begin
        style_left <= style_left - 1;
      end
      case (stall_style)
        0: rsp_ch.ready <= 1'b1;
        1: rsp_ch.ready <= 1'($urandom_range(1));
        2: rsp_ch.ready <= ($urandom_range(7) == 0);
        default: rsp_ch.ready <= ($urandom_range(15) != 0);
      endcase
    end
  end

  task automatic send_cmd(input logic [MODE_W-1:0] mode, input logic [IDX_IN_W-1:0] idx,
                          input logic [VAL_W-1:0] val, input logic [TIME_W-1:0] now);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(12, 1);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(20, 1);
      if (gap > 0) begin
        cmd_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_ch.valid <= 1'b1;
    cmd_ch.mode <= mode;
    cmd_ch.slot_index <= idx;
    cmd_ch.entry_value <= val;
    cmd_ch.now_time <= now;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    table_sb.note_command(mode, idx, val, now);
  endtask

  task automatic settle();
    cmd_ch.valid <= 1'b0;
    burst_left = 0;
    while (table_sb.expected_rsps.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_hold(input logic [TIME_W-1:0] v);
    settle();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    table_sb.hold_time = v;
    cfg_we <= 1'b0;
  endtask

  task automatic send_random();
    int                 pick;
    logic [MODE_W-1:0]  mode;
    logic [IDX_IN_W-1:0] idx;
    logic [VAL_W-1:0]   val;
    case ($urandom_range(19))
      0: clock_s = clock_s + $urandom;
      1, 2, 3: clock_s = clock_s + table_sb.hold_time + 32'($urandom_range(2)) - 32'd1;
      default: clock_s = clock_s + 32'($urandom_range(12));
    endcase
    pick = $urandom_range(99);
    if (pick < 34) mode = (table_sb.in_use < 64) ? MODE_ALLOC : MODE_STOP;
    else if (pick < 50) mode = MODE_GET;
    else if (pick < 72) mode = MODE_STOP;
    else if (pick < 79) mode = MODE_FIRST;
    else if (pick < 92) mode = MODE_NEXT;
    else if (pick < 94) mode = MODE_CLEAR;
    else if (pick < 97) mode = MODE_BAD_LO;
    else mode = MODE_BAD_HI;
    case ($urandom_range(9))
      0: idx = 16'($urandom_range(16'hFFFF));
      1, 2: idx = 16'($urandom_range(SLOTS - 1));
      default: idx = table_sb.pick_used();
    endcase
    case ($urandom_range(9))
      0: val = '0;
      1: val = '1;
      default: val = $urandom;
    endcase
    send_cmd(mode, idx, val, clock_s);
  endtask

  initial begin
    int ph;
    int n;
    table_sb = new();
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    cmd_ch.valid <= 1'b0;
    cmd_ch.mode <= MODE_ALLOC;
    cmd_ch.slot_index <= '0;
    cmd_ch.entry_value <= '0;
    cmd_ch.now_time <= '0;
    squeeze_req <= 1'b0;
    burst_left = 0;
    clock_s = '0;
    phase_holds = '{32'd5, 32'd0, 32'd1, 32'hFFFF_FFFF, 32'd0, HOLD_RESET};
    phase_holds[4] = $urandom_range(1000, 2);
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    send_cmd(MODE_FIRST, 16'd0, 32'd0, 32'd0);
    send_cmd(MODE_NEXT, 16'd0, 32'd0, 32'd0);
    send_cmd(MODE_GET, 16'd0, 32'd0, 32'd0);
    send_cmd(MODE_STOP, 16'd0, 32'd0, 32'd0);
    send_cmd(MODE_ALLOC, 16'd0, 32'd0, 32'd100);
    send_cmd(MODE_ALLOC, 16'd0, 32'hFFFF_FFFF, 32'd100);
    send_cmd(MODE_ALLOC, 16'd0, 32'h1234_5678, 32'd100);
    send_cmd(MODE_GET, 16'd0, 32'd0, 32'd0);
    send_cmd(MODE_GET, 16'hFFFF, 32'd0, 32'd0);
    send_cmd(MODE_STOP, 16'hFFFF, 32'd0, 32'd0);
    send_cmd(MODE_NEXT, 16'hFFFF, 32'd0, 32'd0);
    send_cmd(MODE_NEXT, 16'd2, 32'd0, 32'd0);
    send_cmd(MODE_STOP, 16'd0, 32'd0, 32'd100);
    send_cmd(MODE_STOP, 16'd1, 32'd0, 32'd100);
    send_cmd(MODE_FIRST, 16'd0, 32'd0, 32'd0);
    send_cmd(MODE_ALLOC, 16'd0, 32'h0000_0001, 32'd280);
    send_cmd(MODE_ALLOC, 16'd0, 32'h8000_0000, 32'd281);
    send_cmd(MODE_ALLOC, 16'd0, 32'h5555_AAAA, 32'd281);
    send_cmd(MODE_BAD_LO, 16'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(MODE_BAD_HI, 16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_cmd(MODE_CLEAR, 16'd0, 32'd0, 32'd0);
    write_hold(32'hFFFF_FFFE);
    send_cmd(MODE_ALLOC, 16'd0, 32'hA5A5_A5A5, 32'd50);
    send_cmd(MODE_STOP, 16'd0, 32'd0, 32'h0000_0010);
    send_cmd(MODE_ALLOC, 16'd0, 32'h5A5A_5A5A, 32'h0000_000F);
    write_hold(32'd0);
    send_cmd(MODE_STOP, 16'd0, 32'd0, 32'd5);
    send_cmd(MODE_ALLOC, 16'd0, 32'h0F0F_0F0F, 32'd6);
    send_cmd(MODE_CLEAR, 16'd0, 32'd0, 32'd0);

    // Fill the low slots with the clock about to wrap, then close and reuse one across the wrap.
    write_hold(HOLD_RESET);
    clock_s = 32'hFFFF_FF00;
    for (n = 0; n < FILL_ITEMS; n++) begin
      clock_s = clock_s + 32'($urandom_range(3));
      send_cmd(MODE_ALLOC, 16'd0, $urandom, clock_s);
    end
    send_cmd(MODE_ALLOC, 16'd0, 32'hDEAD_0001, clock_s);
    send_cmd(MODE_NEXT, 16'(SLOTS - 1), 32'd0, clock_s);
    send_cmd(MODE_FIRST, 16'd0, 32'd0, clock_s);
    send_cmd(MODE_GET, 16'(FILL_ITEMS - 1), 32'd0, clock_s);
    send_cmd(MODE_STOP, 16'(FILL_ITEMS - 1), 32'd0, clock_s);
    send_cmd(MODE_ALLOC, 16'd0, 32'hDEAD_0002, clock_s + HOLD_RESET);
    clock_s = clock_s + HOLD_RESET + 32'd1;
    send_cmd(MODE_ALLOC, 16'd0, 32'hDEAD_0003, clock_s);
    write_hold(32'd0);
    send_cmd(MODE_STOP, 16'(FILL_ITEMS / 2), 32'd0, clock_s);
    send_cmd(MODE_ALLOC, 16'd0, 32'hDEAD_0004, clock_s);
    send_cmd(MODE_ALLOC, 16'd0, 32'hDEAD_0005, clock_s);
    send_cmd(MODE_CLEAR, 16'd0, 32'd0, clock_s);

    for (ph = 0; ph < PHASES; ph++) begin
      write_hold(phase_holds[ph]);
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 1 && n == 40) squeeze_req <= 1'b1;
        send_random();
      end
    end

    settle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Checked %0d response beats; %0d closed slots reused, %0d allocations refused.",
             table_sb.beats_checked, table_sb.reuses, table_sb.full_misses);
    $display("Mix: alloc %0d, get %0d, stop %0d, first %0d, next %0d, clear %0d, unknown %0d.",
             table_sb.mode_hits[MODE_ALLOC], table_sb.mode_hits[MODE_GET],
             table_sb.mode_hits[MODE_STOP], table_sb.mode_hits[MODE_FIRST],
             table_sb.mode_hits[MODE_NEXT], table_sb.mode_hits[MODE_CLEAR],
             table_sb.mode_hits[MODE_BAD_LO] + table_sb.mode_hits[MODE_BAD_HI]);
    if (table_sb.mismatches == 0 && table_sb.expected_rsps.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
